// ----- src/cfau_pkg.sv -----
// shared types and codes of the custom float arithmetic unit
package cfau_pkg;

	localparam int SIG_BITS_DEF = 26;
	localparam int EXP_BITS_DEF = 6;

	localparam logic [2:0] ACT_ADD = 3'd0;
	localparam logic [2:0] ACT_SUB = 3'd1;
	localparam logic [2:0] ACT_MUL = 3'd2;
	localparam logic [2:0] ACT_DIV = 3'd3;
	localparam logic [2:0] ACT_NEG = 3'd4;

	typedef enum logic [2:0] {
		KIND_ADD,
		KIND_MUL,
		KIND_DIV,
		KIND_DZ,
		KIND_NEG,
		KIND_ZERO
	} kind_t;

	typedef struct packed {
		kind_t kind;
		logic  neg;
	} ctl_t;

	localparam int CTL_W = $bits(ctl_t);

endpackage

// ----- src/cfau_front.sv -----
// front stage: accepts requests, unpacks and classifies them
module cfau_front #(
	parameter int SIG_BITS = 26,
	parameter int EXP_BITS = 6
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [2:0]                   action,
	input  logic [EXP_BITS+SIG_BITS-1:0] operand_a,
	input  logic [EXP_BITS+SIG_BITS-1:0] operand_b,
	output logic                         out_valid,
	input  logic                         out_stall,
	output cfau_pkg::ctl_t               out_ctl,
	output logic [EXP_BITS-1:0]          out_ea,
	output logic [EXP_BITS-1:0]          out_eb,
	output logic [SIG_BITS-1:0]          out_sa,
	output logic [SIG_BITS-1:0]          out_sb
);
	import cfau_pkg::*;

	localparam int S = SIG_BITS;
	localparam int W = EXP_BITS + SIG_BITS;

	logic [EXP_BITS-1:0] ea, eb;
	logic [S-1:0]        sa, sb, sb_neg, ma, mb;
	ctl_t                ctl_d;
	logic [EXP_BITS-1:0] ea_d, eb_d;
	logic [S-1:0]        sa_d, sb_d;
	logic                vld_q;
	ctl_t                ctl_q;
	logic [EXP_BITS-1:0] ea_q, eb_q;
	logic [S-1:0]        sa_q, sb_q;

	assign ea     = operand_a[W-1:S];
	assign eb     = operand_b[W-1:S];
	assign sa     = operand_a[S-1:0];
	assign sb     = operand_b[S-1:0];
	assign sb_neg = S'(0) - sb;
	assign ma     = sa[S-1] ? S'(0) - sa : sa;
	assign mb     = sb[S-1] ? S'(0) - sb : sb;

	always_comb begin
		ctl_d.kind = KIND_ZERO;
		ctl_d.neg  = 1'b0;
		ea_d       = ea;
		eb_d       = eb;
		sa_d       = sa;
		sb_d       = sb;
		case (action)
			ACT_ADD: begin
				ctl_d.kind = KIND_ADD;
			end
			ACT_SUB: begin
				ctl_d.kind = KIND_ADD;
				sb_d       = sb_neg;
			end
			ACT_MUL: begin
				ctl_d.kind = KIND_MUL;
				ctl_d.neg  = sa[S-1] ^ sb[S-1];
				sa_d       = ma;
				sb_d       = mb;
			end
			ACT_DIV: begin
				sa_d = ma;
				sb_d = mb;
				if (mb == '0) begin
					ctl_d.kind = KIND_DZ;
					ctl_d.neg  = sa[S-1];
				end else begin
					ctl_d.kind = KIND_DIV;
					ctl_d.neg  = sa[S-1] ^ sb[S-1];
				end
			end
			ACT_NEG: begin
				ctl_d.kind = KIND_NEG;
				ea_d       = eb;
				sa_d       = sb_neg;
			end
			default: begin
				ctl_d.kind = KIND_ZERO;
			end
		endcase
	end

	assign in_stall = vld_q && out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (!in_stall) begin
			vld_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			ctl_q <= ctl_d;
			ea_q  <= ea_d;
			eb_q  <= eb_d;
			sa_q  <= sa_d;
			sb_q  <= sb_d;
		end
	end

	assign out_valid = vld_q;
	assign out_ctl   = ctl_q;
	assign out_ea    = ea_q;
	assign out_eb    = eb_q;
	assign out_sa    = sa_q;
	assign out_sb    = sb_q;

endmodule

// ----- src/cfau_queue.sv -----
// two-entry request queue between front and back
module cfau_queue #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [WIDTH-1:0] in_data,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [WIDTH-1:0] out_data
);
	import cfau_pkg::*;

	logic [WIDTH-1:0] mem [0:1];
	logic             wr_q, rd_q;
	logic [1:0]       cnt_q;
	logic             push, pop;

	assign in_stall  = (cnt_q == 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign out_data  = mem[rd_q];
	assign push      = in_valid && !in_stall;
	assign pop       = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_q] <= in_data;
		end
	end

`ifndef ASSERT_OFF
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3) else $error("queue count out of range");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd1) |-> (wr_q != rd_q)) else $error("queue pointers disagree with count");
`endif

endmodule

// ----- src/cfau_back.sv -----
// back pipeline: add, multiply, long division, normalize and pack
module cfau_back #(
	parameter int SIG_BITS = 26,
	parameter int EXP_BITS = 6
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  cfau_pkg::ctl_t               in_ctl,
	input  logic [EXP_BITS-1:0]          in_ea,
	input  logic [EXP_BITS-1:0]          in_eb,
	input  logic [SIG_BITS-1:0]          in_sa,
	input  logic [SIG_BITS-1:0]          in_sb,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [EXP_BITS+SIG_BITS-1:0] result,
	output logic                         div_by_zero
);
	import cfau_pkg::*;

	localparam int S  = SIG_BITS;
	localparam int E  = EXP_BITS;
	localparam int W  = E + S;
	localparam int V  = 2 * S;
	localparam int DS = 2 * S;
	localparam int LW = $clog2(V + 1);
	localparam int SW = LW + 1;
	localparam int XW = (SW > E) ? SW : E;
	localparam logic [E-1:0] SM1     = E'(S - 1);
	localparam logic [E-1:0] DZ_EXP  = E'((1 << (E - 2)) - 1);
	localparam logic [S-1:0] MAX_POS = S'((64'd1 << (S - 2)) - 64'd1);
	localparam logic [S-1:0] MIN_NEG = S'(64'd1 << (S - 1));

	logic en;

	// stage 1: alignment and sum, product, divider load
	logic                 a_gt;
	logic [E:0]           dlt;
	logic signed [S-1:0]  sas, sbs;
	logic signed [S:0]    sum;
	logic [V-1:0]         prod;
	logic [V-1:0]         val_d;
	logic [E-1:0]         expb_d;

	assign a_gt = $signed(in_ea) > $signed(in_eb);
	assign dlt  = a_gt ? ({in_ea[E-1], in_ea} - {in_eb[E-1], in_eb})
	                   : ({in_eb[E-1], in_eb} - {in_ea[E-1], in_ea});
	assign sas  = a_gt ? $signed(in_sa) : ($signed(in_sa) >>> dlt);
	assign sbs  = a_gt ? ($signed(in_sb) >>> dlt) : $signed(in_sb);
	assign sum  = {sas[S-1], sas} + {sbs[S-1], sbs};
	assign prod = in_sa * in_sb;

	always_comb begin
		val_d  = V'(in_sa);
		expb_d = in_ea;
		case (in_ctl.kind)
			KIND_ADD: begin
				val_d  = {{(S - 1){sum[S]}}, sum};
				expb_d = a_gt ? in_ea : in_eb;
			end
			KIND_MUL: begin
				val_d  = prod;
				expb_d = in_ea + in_eb - SM1;
			end
			KIND_DIV: begin
				val_d  = {in_sa, S'(0)};
				expb_d = in_ea - in_eb - E'(1);
			end
			default: begin
				val_d  = V'(in_sa);
				expb_d = in_ea;
			end
		endcase
	end

	// divider chain, one quotient bit per stage; other requests ride along
	logic         vld_s1  [0:DS];
	ctl_t         ctl_s1  [0:DS];
	logic [V-1:0] val_s1  [0:DS];
	logic [S-1:0] rem_s1  [0:DS];
	logic [S-1:0] dvs_s1  [0:DS];
	logic [E-1:0] expb_s1 [0:DS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1[0] <= 1'b0;
		end else if (en) begin
			vld_s1[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s1[0]  <= in_ctl;
			val_s1[0]  <= val_d;
			rem_s1[0]  <= '0;
			dvs_s1[0]  <= in_sb;
			expb_s1[0] <= expb_d;
		end
	end

	for (genvar k = 0; k < DS; k++) begin : g_div
		logic [S:0]   t;
		logic [S:0]   diff;
		logic         ge;
		logic         is_div;

		assign t      = {rem_s1[k], val_s1[k][V-1]};
		assign diff   = t - {1'b0, dvs_s1[k]};
		assign ge     = t >= {1'b0, dvs_s1[k]};
		assign is_div = (ctl_s1[k].kind == KIND_DIV);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s1[k+1] <= 1'b0;
			end else if (en) begin
				vld_s1[k+1] <= vld_s1[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				ctl_s1[k+1]  <= ctl_s1[k];
				dvs_s1[k+1]  <= dvs_s1[k];
				expb_s1[k+1] <= expb_s1[k];
				if (is_div) begin
					val_s1[k+1] <= {val_s1[k][V-2:0], ge};
					rem_s1[k+1] <= ge ? diff[S-1:0] : t[S-1:0];
				end else begin
					val_s1[k+1] <= val_s1[k];
					rem_s1[k+1] <= rem_s1[k];
				end
			end
		end
	end

	// stage 2: leading bit search
	logic [V-1:0]        srch;
	logic [LW-1:0]       len;
	logic [LW-1:0]       len_fix;
	logic signed [SW-1:0] sh_d;
	logic                is_add_e;

	assign is_add_e = (ctl_s1[DS].kind == KIND_ADD);
	assign srch     = (is_add_e && val_s1[DS][V-1]) ? ~val_s1[DS] : val_s1[DS];

	always_comb begin
		len = '0;
		for (int i = 0; i < V; i++) begin
			if (srch[i]) begin
				len = LW'(i + 1);
			end
		end
	end

	assign len_fix = (len == '0) ? LW'(1) : len;
	assign sh_d    = $signed({1'b0, len_fix}) - $signed(SW'(S - 1));

	logic                 vld_s2;
	ctl_t                 ctl_s2;
	logic [V-1:0]         val_s2;
	logic [E-1:0]         expb_s2;
	logic signed [SW-1:0] sh_s2;
	logic                 zero_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1[DS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s2  <= ctl_s1[DS];
			val_s2  <= val_s1[DS];
			expb_s2 <= expb_s1[DS];
			sh_s2   <= sh_d;
			zero_s2 <= (val_s1[DS] == '0);
		end
	end

	// stage 3: shift, sign and pack into the output register
	logic [LW-1:0]        rs, ls;
	logic [SW-1:0]        sh_n;
	logic [V-1:0]         shv;
	logic [S-1:0]         sig;
	logic [XW-1:0]        shx;
	logic [W-1:0]         res_d;
	logic                 dz_d;

	assign sh_n = SW'(0) - sh_s2;
	assign rs   = sh_s2[LW-1:0];
	assign ls   = sh_n[LW-1:0];
	assign shx  = XW'(sh_s2);

	always_comb begin
		if (sh_s2 > 0) begin
			if (ctl_s2.kind == KIND_ADD) begin
				shv = $signed(val_s2) >>> rs;
			end else begin
				shv = val_s2 >> rs;
			end
		end else begin
			shv = val_s2 << ls;
		end
	end

	assign sig = ctl_s2.neg ? S'(0) - shv[S-1:0] : shv[S-1:0];

	always_comb begin
		res_d = '0;
		dz_d  = 1'b0;
		case (ctl_s2.kind)
			KIND_ADD, KIND_MUL, KIND_DIV: begin
				res_d = zero_s2 ? W'(0) : {expb_s2 + shx[E-1:0], sig};
			end
			KIND_NEG: begin
				res_d = {expb_s2, val_s2[S-1:0]};
			end
			KIND_DZ: begin
				res_d = {DZ_EXP, ctl_s2.neg ? MIN_NEG : MAX_POS};
				dz_d  = 1'b1;
			end
			default: begin
				res_d = '0;
			end
		endcase
	end

	logic         vld_s3;
	logic [W-1:0] res_s3;
	logic         dz_s3;

	assign en       = !vld_s3 || !out_stall;
	assign in_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s3 <= res_d;
			dz_s3  <= dz_d;
		end
	end

	assign out_valid   = vld_s3;
	assign result      = res_s3;
	assign div_by_zero = dz_s3;

`ifndef ASSERT_OFF
	a_dz_exp: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s3 && dz_s3) |-> (res_s3[W-1:S] == DZ_EXP))
		else $error("divide by zero result has wrong exponent");
	a_hold_s2: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s2 && !en) |=> vld_s2) else $error("stalled request lost in stage 2");
	a_chain_move: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1[0] && en) |=> vld_s1[1]) else $error("divider chain dropped a request");
`endif

endmodule

// ----- src/custom_float_arith_unit.sv -----
// top level of the custom float arithmetic unit
// Takes one request per cycle while in_stall is low (add, subtract, multiply, divide, negate)
// on packed words of a signed exponent above a signed significand and returns one result word
// and a divide-by-zero flag per request, in order. A registered front stage decodes the
// request into a two-entry queue; the back pipeline is fully pipelined, its depth set by the
// long divider that retires one quotient bit per stage; all actions take the same path so
// results keep their order. A stall on the output freezes the back pipeline, and the queue and
// the front register absorb up to three more requests before the input stalls.
module custom_float_arith_unit #(
	parameter int SIG_BITS = cfau_pkg::SIG_BITS_DEF,
	parameter int EXP_BITS = cfau_pkg::EXP_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [2:0]                   action,
	input  logic [EXP_BITS+SIG_BITS-1:0] operand_a,
	input  logic [EXP_BITS+SIG_BITS-1:0] operand_b,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [EXP_BITS+SIG_BITS-1:0] result,
	output logic                         div_by_zero
);
	import cfau_pkg::*;

	localparam int S  = SIG_BITS;
	localparam int E  = EXP_BITS;
	localparam int QW = CTL_W + 2 * E + 2 * S;

	logic          f_valid, f_stall;
	ctl_t          f_ctl;
	logic [E-1:0]  f_ea, f_eb;
	logic [S-1:0]  f_sa, f_sb;
	logic          q_valid, q_stall;
	logic [QW-1:0] q_in, q_out;
	ctl_t          b_ctl;

	cfau_front #(.SIG_BITS(S), .EXP_BITS(E)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.action    (action),
		.operand_a (operand_a),
		.operand_b (operand_b),
		.out_valid (f_valid),
		.out_stall (f_stall),
		.out_ctl   (f_ctl),
		.out_ea    (f_ea),
		.out_eb    (f_eb),
		.out_sa    (f_sa),
		.out_sb    (f_sb)
	);

	assign q_in = {f_ctl, f_ea, f_eb, f_sa, f_sb};

	cfau_queue #(.WIDTH(QW)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_stall  (f_stall),
		.in_data   (q_in),
		.out_valid (q_valid),
		.out_stall (q_stall),
		.out_data  (q_out)
	);

	assign b_ctl = ctl_t'(q_out[QW-1 -: CTL_W]);

	cfau_back #(.SIG_BITS(S), .EXP_BITS(E)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (q_valid),
		.in_stall    (q_stall),
		.in_ctl      (b_ctl),
		.in_ea       (q_out[2 * S + 2 * E - 1 -: E]),
		.in_eb       (q_out[2 * S + E - 1 -: E]),
		.in_sa       (q_out[2 * S - 1 -: S]),
		.in_sb       (q_out[S - 1 -: S]),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.result      (result),
		.div_by_zero (div_by_zero)
	);

endmodule

// ----- bench/custom_float_arith_unit_tb.sv -----
// self-checking testbench of the custom float arithmetic unit
`timescale 1ns / 100ps

module custom_float_arith_unit_tb;
	import cfau_pkg::*;

	localparam int SB = 26;
	localparam int EB = 6;
	localparam int LATENCY = 2 * SB + 8;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int RANDOM_COUNT = 1530;

	typedef struct {
		logic [2:0]  act;
		logic [31:0] a;
		logic [31:0] b;
		bit          known;
		logic [31:0] res;
		logic        dz;
	} row_t;

	typedef struct {
		logic [31:0] res;
		logic        dz;
	} outcome_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [2:0]  action;
	logic [31:0] operand_a;
	logic [31:0] operand_b;
	logic        out_valid;
	logic        out_stall;
	logic [31:0] result;
	logic        div_by_zero;

	outcome_t pending_results[$];
	int       fail_count;
	int       idle_cycles;
	bit       hold_off_req;

	custom_float_arith_unit DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.action      (action),
		.operand_a   (operand_a),
		.operand_b   (operand_b),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.result      (result),
		.div_by_zero (div_by_zero)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic int bit_length(logic [63:0] u);
		int n;
		n = 0;
		for (int i = 0; i < 64; i++)
			if (u[i]) n = i + 1;
		return n;
	endfunction

	function automatic int exp_field(logic [31:0] w);
		logic signed [EB-1:0] e;
		e = w[31:SB];
		return int'(e);
	endfunction

	function automatic logic signed [63:0] sig_field(logic [31:0] w);
		logic signed [SB-1:0] s;
		s = w[SB-1:0];
		return 64'(s);
	endfunction

	function automatic logic [63:0] sig_magnitude(logic [31:0] w);
		logic signed [63:0] s;
		s = sig_field(w);
		return s < 0 ? -s : s;
	endfunction

	function automatic logic [31:0] pack_word(int e, logic [63:0] s);
		logic [EB-1:0] ef;
		ef = e[EB-1:0];
		return {ef, s[SB-1:0]};
	endfunction

	function automatic logic [31:0] negate_word(logic [31:0] w);
		logic [SB-1:0] s;
		s = -w[SB-1:0];
		return {w[31:SB], s};
	endfunction

	function automatic logic signed [63:0] shift_sign(logic signed [63:0] u, int d);
		if (d >= 63) return u < 0 ? -64'sd1 : 64'sd0;
		return u >>> d;
	endfunction

	function automatic logic [31:0] sum_word(logic [31:0] a, logic [31:0] b);
		int ea, eb, e, len, sh;
		logic signed [63:0] sa, sb, s;
		ea = exp_field(a);
		eb = exp_field(b);
		sa = sig_field(a);
		sb = sig_field(b);
		e = ea;
		if (ea > eb) begin
			sb = shift_sign(sb, ea - eb);
		end else if (eb > ea) begin
			sa = shift_sign(sa, eb - ea);
			e = eb;
		end
		s = sa + sb;
		if (s == 0) return 32'd0;
		if (s < 0) begin
			len = bit_length(~s);
			if (len == 0) len = 1;
		end else begin
			len = bit_length(s);
		end
		sh = len - (SB - 1);
		if (sh > 0) s = s >>> sh;
		else if (sh < 0) s = s <<< -sh;
		return pack_word(e + sh, s);
	endfunction

	function automatic logic [31:0] scaled_word(logic [63:0] p, int e, bit neg);
		int sh;
		logic [63:0] r;
		sh = bit_length(p) - (SB - 1);
		r = p;
		if (sh > 0) r = p >> sh;
		else if (sh < 0) r = p << -sh;
		if (neg) r = -r;
		return pack_word(e + sh, r);
	endfunction

	function automatic outcome_t compute_outcome(logic [2:0] act, logic [31:0] a,
			logic [31:0] b);
		outcome_t o;
		logic [63:0] p;
		bit neg;
		o.res = 32'd0;
		o.dz = 1'b0;
		neg = a[SB-1] != b[SB-1];
		case (act)
			ACT_ADD: o.res = sum_word(a, b);
			ACT_SUB: o.res = sum_word(a, negate_word(b));
			ACT_MUL: begin
				p = sig_magnitude(a) * sig_magnitude(b);
				if (p != 0) o.res = scaled_word(p, exp_field(a) + exp_field(b) - (SB - 1), neg);
			end
			ACT_DIV: begin
				if (sig_magnitude(b) == 0) begin
					o.dz = 1'b1;
					if (!a[SB-1]) o.res = pack_word((1 << (EB - 2)) - 1, (64'd1 << (SB - 2)) - 1);
					else o.res = pack_word((1 << (EB - 2)) - 1, 64'd1 << (SB - 1));
				end else begin
					p = (sig_magnitude(a) << SB) / sig_magnitude(b);
					if (p != 0) o.res = scaled_word(p, exp_field(a) - exp_field(b) - 1, neg);
				end
			end
			ACT_NEG: o.res = negate_word(b);
			default: o.res = 32'd0;
		endcase
		return o;
	endfunction

	function automatic logic [31:0] random_word();
		logic [31:0] w;
		w = $urandom;
		case ($urandom_range(0, 7))
			0: w[SB-1:0] = '0;
			1: w[SB-1:0] = {1'b1, {(SB-1){1'b0}}};
			2: w[SB-1:0] = {2'b01, {(SB-2){1'b1}}};
			3: w[SB-1:0] = SB'($urandom_range(0, 15));
			default: ;
		endcase
		if ($urandom_range(0, 3) == 0) w[31:SB] = EB'($urandom_range(0, 3));
		return w;
	endfunction

	task automatic send_request(logic [2:0] act, logic [31:0] a, logic [31:0] b);
		outcome_t o;
		o = compute_outcome(act, a, b);
		action <= act;
		operand_a <= a;
		operand_b <= b;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		pending_results.push_back(o);
		@(negedge clk);
		if ($urandom_range(0, 2) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(0, 9) == 0 ? $urandom_range(5, 40) : $urandom_range(1, 3))
				@(negedge clk);
		end
	endtask

	// receiver side with random stalls and one long hold-off on request
	initial begin
		out_stall = 1'b1;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				out_stall <= 1'b1;
				repeat (150) @(negedge clk);
				hold_off_req = 1'b0;
			end
			case ($urandom_range(0, 19))
				0: out_stall <= 1'b1;
				1: begin
					out_stall <= 1'b1;
					repeat ($urandom_range(5, 30)) @(negedge clk);
				end
				2, 3: out_stall <= 1'b1;
				default: out_stall <= 1'b0;
			endcase
		end
	end

	// result checking at the rising edge
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result %h", result);
				fail_count++;
			end else begin
				outcome_t o;
				o = pending_results.pop_front();
				if (result !== o.res) begin
					$error("result mismatch: expected %h actual %h", o.res, result);
					fail_count++;
				end
				if (div_by_zero !== o.dz) begin
					$error("div_by_zero mismatch: expected %b actual %b", o.dz, div_by_zero);
					fail_count++;
				end
			end
		end
	end

	// watchdog on cycles with no accepted request or result
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		row_t rows[$];
		row_t r;
		logic [31:0] most_neg, max_pos, dz_pos, dz_neg;
		int waited;
		most_neg = {6'd0, 1'b1, 25'd0};
		max_pos = {6'd0, 1'b0, {25{1'b1}}};
		dz_pos = {6'd15, 2'b00, {24{1'b1}}};
		dz_neg = {6'd15, 1'b1, 25'd0};
		fail_count = 0;
		idle_cycles = 0;
		hold_off_req = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		action = ACT_ADD;
		operand_a = '0;
		operand_b = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed table: known results only where obvious
		rows = '{
			'{ACT_ADD, 32'h0, 32'h0, 1, 32'h0, 1'b0},
			'{ACT_SUB, 32'h1234567, 32'h1234567, 1, 32'h0, 1'b0},
			'{ACT_MUL, 32'h0, 32'hFFFFFFFF, 1, 32'h0, 1'b0},
			'{ACT_DIV, 32'h1000, 32'hFC000000, 1, dz_pos, 1'b1},
			'{ACT_DIV, most_neg, 32'h0, 1, dz_neg, 1'b1},
			'{ACT_NEG, 32'h0, most_neg, 1, most_neg, 1'b0},
			'{ACT_NEG, 32'h0, 32'h7C000000, 1, 32'h7C000000, 1'b0},
			'{3'd5, 32'hFFFFFFFF, 32'hFFFFFFFF, 1, 32'h0, 1'b0},
			'{3'd7, 32'h12345678, 32'h9ABCDEF0, 1, 32'h0, 1'b0},
			'{ACT_ADD, max_pos, max_pos, 0, 0, 0},
			'{ACT_ADD, 32'h7C000001, 32'h80000001, 0, 0, 0},
			'{ACT_ADD, 32'h82000000, 32'h7DFFFFFF, 0, 0, 0},
			'{ACT_ADD, 32'hFFFFFFFF, 32'h00000001, 0, 0, 0},
			'{ACT_SUB, most_neg, max_pos, 0, 0, 0},
			'{ACT_SUB, 32'h00000001, 32'h7E000000, 0, 0, 0},
			'{ACT_MUL, most_neg, most_neg, 0, 0, 0},
			'{ACT_MUL, max_pos, 32'hFFFFFFFF, 0, 0, 0},
			'{ACT_MUL, 32'h7C000003, 32'h7C000005, 0, 0, 0},
			'{ACT_DIV, max_pos, 32'h00000001, 0, 0, 0},
			'{ACT_DIV, 32'h00000001, most_neg, 0, 0, 0},
			'{ACT_DIV, 32'h80000000, 32'h00000005, 0, 0, 0},
			'{ACT_DIV, 32'h83FFFFFF, 32'h7DFFFFFF, 0, 0, 0},
			'{ACT_NEG, 32'h0, 32'hFFFFFFFF, 0, 0, 0}
		};
		foreach (rows[i]) begin
			r = rows[i];
			if (r.known) begin
				outcome_t o;
				o = compute_outcome(r.act, r.a, r.b);
				if (o.res !== r.res || o.dz !== r.dz) begin
					$error("table row %0d disagrees with prediction", i);
					fail_count++;
				end
			end
			send_request(r.act, r.a, r.b);
		end

		for (int n = 0; n < RANDOM_COUNT; n++) begin
			logic [2:0] act;
			act = $urandom_range(0, 19) == 0 ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
			if (n == 300) hold_off_req = 1'b1;
			// sender waits for the pipeline to drain once
			if (n == 800) begin
				in_valid <= 1'b0;
				while (pending_results.size() != 0) @(negedge clk);
			end
			send_request(act, random_word(), random_word());
		end
		in_valid <= 1'b0;

		waited = 0;
		while (pending_results.size() != 0 && waited < 100000) begin
			@(negedge clk);
			waited++;
		end
		repeat (LATENCY) @(negedge clk);
		if (fail_count == 0 && pending_results.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

// ----- files.f -----
src/cfau_pkg.sv
src/cfau_front.sv
src/cfau_queue.sv
src/cfau_back.sv
src/custom_float_arith_unit.sv
bench/custom_float_arith_unit_tb.sv
